/* hdl/vectored_interrupt_controller_macros.svh */
// assertion macros shared by the interrupt controller rtl
`ifndef VECTORED_INTERRUPT_CONTROLLER_MACROS_SVH
`define VECTORED_INTERRUPT_CONTROLLER_MACROS_SVH

// same-cycle implication, checked outside reset
`define VIC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("vic check failed");

// next-cycle implication, checked outside reset
`define VIC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("vic check failed");

`endif

/* hdl/vic_pkg.sv */
// shared types and constants of the interrupt controller
package vic_pkg;

    // item kinds
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_RAISE = 2'd2;

    // register word indexes
    localparam logic [2:0] REG_SRCPND    = 3'd0;
    localparam logic [2:0] REG_INTMOD    = 3'd1;
    localparam logic [2:0] REG_INTMSK    = 3'd2;
    localparam logic [2:0] REG_PRIORITY  = 3'd3;
    localparam logic [2:0] REG_INTPND    = 3'd4;
    localparam logic [2:0] REG_INTOFFSET = 3'd5;
    localparam logic [2:0] REG_SUBSRCPND = 3'd6;
    localparam logic [2:0] REG_INTSUBMSK = 3'd7;

    // source lines with sub-sources
    localparam logic [4:0] LINE_ADC   = 5'd31;
    localparam logic [4:0] LINE_UART0 = 5'd28;
    localparam logic [4:0] LINE_UART1 = 5'd23;
    localparam logic [4:0] LINE_UART2 = 5'd15;

    localparam int SUB_W = 11;
    localparam logic [SUB_W-1:0] SUB_ADC    = 11'h400;
    localparam logic [SUB_W-1:0] SUB_UART0  = 11'h007;
    localparam logic [SUB_W-1:0] SUB_UART1  = 11'h038;
    localparam logic [SUB_W-1:0] SUB_UART2  = 11'h1c0;
    localparam logic [SUB_W-1:0] SUB_MASK_RESET = 11'h7ff;

    localparam logic [31:0] SRC_MASK_RESET = 32'hffff_ffff;
    localparam logic [31:0] PRIORITY_RESET = 32'h0000_007f;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  reg_index;
        logic [31:0] write_data;
        logic [4:0]  line;
    } vic_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_pulse;
        logic        firq_pulse;
        logic        fast_mode_conflict;
    } vic_result_t;

endpackage

/* hdl/vectored_interrupt_controller.sv */
// top level of the vectored interrupt controller
//
//  channel  dir  ports                     contents
//  s_       in   tvalid tready tdata tuser bus read, bus write or line raise
//  m_       out  tvalid tready tdata       read data and request pulses
//
// one item per cycle sustained while m_ does not stall; input register, then
// result register; the register update and result logic sit between them
// reset sets the control registers to their reset values and empties both stages
// a stall on m_ holds the result register; s_tready drops only when both
// stages are full and the result is not taken
`include "vectored_interrupt_controller_macros.svh"

module vectored_interrupt_controller
    import vic_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input item
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // reg_index[2:0], write_data[34:3], line[39:35]
    input  logic [1:0]  s_tuser,   // action[1:0]
    // result item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // read_data[31:0], irq_pulse[32], firq_pulse[33],
                                   // fast_mode_conflict[34], zero fill[39:35]
);

    // input stage
    logic        in_valid_reg, in_valid_next;
    vic_item_t   in_item_reg;

    // result stage
    logic        out_valid_reg, out_valid_next;
    vic_result_t out_result_reg;

    vic_result_t result;
    logic        advance;   // input stage may move into the result stage
    logic        commit;    // item in input stage updates registers this cycle
    logic        s_accept;

    assign advance  = !out_valid_reg || m_tready;
    assign commit   = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // register file; all state changes land at the commit edge
    vic_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .commit_en (commit),
        .item      (in_item_reg),
        .result    (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (commit) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.action     <= s_tuser;
            in_item_reg.reg_index  <= s_tdata[2:0];
            in_item_reg.write_data <= s_tdata[34:3];
            in_item_reg.line       <= s_tdata[39:35];
        end
        if (commit) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_result_reg.fast_mode_conflict,
                       out_result_reg.firq_pulse, out_result_reg.irq_pulse,
                       out_result_reg.read_data};

    `VIC_ASSERT_NEXT(a_commit_fills_out, aclk, aresetn, commit, m_tvalid)
    `VIC_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `VIC_ASSERT_NOW(a_full_blocks, aclk, aresetn, in_valid_reg && m_tvalid && !m_tready, !s_tready)

endmodule

/* hdl/vic_regs.sv */
// register file and update logic of the interrupt controller
`include "vectored_interrupt_controller_macros.svh"

module vic_regs
    import vic_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        commit_en,
    input  vic_item_t   item,
    output vic_result_t result
);

    logic [31:0]      src_pnd_reg,  src_pnd_next;
    logic [31:0]      int_mod_reg,  int_mod_next;
    logic [31:0]      int_msk_reg,  int_msk_next;
    logic [31:0]      priority_reg, priority_next;
    logic [31:0]      int_pnd_reg,  int_pnd_next;
    logic [4:0]       offset_reg,   offset_next;
    logic [SUB_W-1:0] sub_pnd_reg,  sub_pnd_next;
    logic [SUB_W-1:0] sub_msk_reg,  sub_msk_next;

    logic [31:0]      line_bit;
    logic [SUB_W-1:0] sub_raised;

    assign line_bit = 32'd1 << item.line;

    always_comb begin
        src_pnd_next  = src_pnd_reg;
        int_mod_next  = int_mod_reg;
        int_msk_next  = int_msk_reg;
        priority_next = priority_reg;
        int_pnd_next  = int_pnd_reg;
        offset_next   = offset_reg;
        sub_pnd_next  = sub_pnd_reg;
        sub_msk_next  = sub_msk_reg;
        sub_raised    = sub_pnd_reg;
        result        = '0;

        case (item.action)
            ACT_READ: begin
                case (item.reg_index)
                    REG_SRCPND:    result.read_data = src_pnd_reg;
                    REG_INTMOD:    result.read_data = int_mod_reg;
                    REG_INTMSK:    result.read_data = int_msk_reg;
                    REG_PRIORITY:  result.read_data = priority_reg;
                    REG_INTPND:    result.read_data = int_pnd_reg;
                    REG_INTOFFSET: result.read_data = {27'd0, offset_reg};
                    REG_SUBSRCPND: result.read_data = {21'd0, sub_pnd_reg};
                    default:       result.read_data = {21'd0, sub_msk_reg};
                endcase
            end
            ACT_WRITE: begin
                case (item.reg_index)
                    REG_SRCPND: begin
                        src_pnd_next = src_pnd_reg & ~item.write_data;
                        offset_next  = '0;
                    end
                    REG_INTMOD:   int_mod_next  = item.write_data;
                    REG_INTMSK:   int_msk_next  = item.write_data;
                    REG_PRIORITY: priority_next = item.write_data;
                    REG_INTPND: begin
                        int_pnd_next = int_pnd_reg & ~item.write_data;
                        offset_next  = '0;
                    end
                    REG_SUBSRCPND:
                        sub_pnd_next = sub_pnd_reg & ~item.write_data[SUB_W-1:0];
                    REG_INTSUBMSK: sub_msk_next = item.write_data[SUB_W-1:0];
                    default: ;  // offset register is read-only
                endcase
            end
            ACT_RAISE: begin
                // sub-source bits; only the uart0 raise applies the sub mask
                case (item.line)
                    LINE_ADC:   sub_raised = sub_pnd_reg | SUB_ADC;
                    LINE_UART0: sub_raised = (sub_pnd_reg | SUB_UART0) & ~sub_msk_reg;
                    LINE_UART1: sub_raised = sub_pnd_reg | SUB_UART1;
                    LINE_UART2: sub_raised = sub_pnd_reg | SUB_UART2;
                    default:    sub_raised = sub_pnd_reg;
                endcase
                sub_pnd_next = sub_raised;
                src_pnd_next = (src_pnd_reg | line_bit) & ~int_msk_reg;
                if ((int_msk_reg & line_bit) == '0) begin
                    if ((int_mod_reg & line_bit) != '0) begin
                        if ((int_mod_reg & ~line_bit) != '0) begin
                            result.fast_mode_conflict = 1'b1;
                        end else begin
                            result.firq_pulse = 1'b1;
                        end
                    end else begin
                        int_pnd_next     = line_bit;
                        offset_next      = item.line;
                        result.irq_pulse = 1'b1;
                    end
                end
            end
            default: ;  // unused kind: no effect, zero result
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_pnd_reg  <= '0;
            int_mod_reg  <= '0;
            int_msk_reg  <= SRC_MASK_RESET;
            priority_reg <= PRIORITY_RESET;
            int_pnd_reg  <= '0;
            offset_reg   <= '0;
            sub_pnd_reg  <= '0;
            sub_msk_reg  <= SUB_MASK_RESET;
        end else if (commit_en) begin
            src_pnd_reg  <= src_pnd_next;
            int_mod_reg  <= int_mod_next;
            int_msk_reg  <= int_msk_next;
            priority_reg <= priority_next;
            int_pnd_reg  <= int_pnd_next;
            offset_reg   <= offset_next;
            sub_pnd_reg  <= sub_pnd_next;
            sub_msk_reg  <= sub_msk_next;
        end
    end

    `VIC_ASSERT_NOW(a_pulse_excl, aclk, aresetn, commit_en, $onehot0({result.irq_pulse, result.firq_pulse, result.fast_mode_conflict}))
    `VIC_ASSERT_NOW(a_read_only_on_read, aclk, aresetn, commit_en && item.action != ACT_READ, result.read_data == '0)
    `VIC_ASSERT_NEXT(a_irq_latch, aclk, aresetn, commit_en && result.irq_pulse, offset_reg == $past(item.line) && $onehot(int_pnd_reg))

endmodule
